// ===== hw/rtl/iprtl_pkg.sv =====
package iprtl_pkg;

    // Default table depth per list
    localparam int TABLE_ENTRIES_DEF = 1024;

    // Field widths
    localparam int ADDR_W   = 32;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;
    localparam int INDEX_W  = 10;

    // Stream widths
    localparam int S_DATA_W = 96;   // range_start, range_end, address
    localparam int S_USER_W = 3;    // operation, list_select
    localparam int M_DATA_W = 80;   // found_start, found_end, entry_index, pad
    localparam int M_USER_W = 2;    // status

    // Operation codes
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd1;
    localparam logic [OP_W-1:0] OP_BUILD  = 2'd2;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd3;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_MISS  = 2'd3;

endpackage

// ===== hw/rtl/iprtl_ram.sv =====
module iprtl_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 2048
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/ip_range_table_lookup.sv =====
// IPv4 range table lookup.
// Keeps two tables of inclusive address ranges (accept, block) in one RAM.
// Input words arrive on s_t*: s_tuser selects operation and table, s_tdata
// carries range bounds and the lookup address. One result word per input
// word leaves on m_t*: m_tuser holds the status, m_tdata the matching range.
// Insert and clear go from the decode state straight to the result state,
// which loads the output register. A lookup runs one binary search step
// per probe; each step waits on one registered RAM read. Build runs an
// insertion sort through the same single RAM port pair, one registered read
// per compare.
// s_tready is high only while the sequencer is idle; one word is in work at
// a time. A finished result sits in the output register while the next
// word is taken; if the receiver stalls, the following result holds in the
// sequencer until the output register frees up.
// Reset (aresetn low, synchronous) empties both tables and drops any pending
// result. Table contents are not cleared; only entries below the count are
// ever read.
module ip_range_table_lookup #(
    parameter int TABLE_ENTRIES = iprtl_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // range_start [31:0], range_end [63:32], address [95:64]
    input  logic [iprtl_pkg::S_DATA_W-1:0] s_tdata,
    // operation [1:0], list_select [2]
    input  logic [iprtl_pkg::S_USER_W-1:0] s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // found_start [31:0], found_end [63:32], entry_index [73:64], zero pad
    output logic [iprtl_pkg::M_DATA_W-1:0] m_tdata,
    // status [1:0]
    output logic [iprtl_pkg::M_USER_W-1:0] m_tuser
);

    localparam int IDX_W  = $clog2(TABLE_ENTRIES);
    localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
    localparam int RAM_AW = IDX_W + 1;
    localparam int RAM_D  = 2 * (1 << IDX_W);
    localparam int AW     = iprtl_pkg::ADDR_W;
    localparam int KEY_W  = 2 * AW;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DEC  = 4'd1;
    localparam logic [3:0] S_SI   = 4'd2;
    localparam logic [3:0] S_SK   = 4'd3;
    localparam logic [3:0] S_SJ   = 4'd4;
    localparam logic [3:0] S_SC   = 4'd5;
    localparam logic [3:0] S_LK   = 4'd6;
    localparam logic [3:0] S_LC   = 4'd7;
    localparam logic [3:0] S_FIN  = 4'd8;

    logic [3:0] state_reg, state_next;
    logic [iprtl_pkg::OP_W-1:0] op_reg, op_next;
    logic sel_reg, sel_next;
    logic [AW-1:0] rs_reg, rs_next, re_reg, re_next, addr_reg, addr_next;
    logic [CNT_W-1:0] acc_cnt_reg, acc_cnt_next, blk_cnt_reg, blk_cnt_next;
    logic [CNT_W-1:0] i_reg, i_next, j_reg, j_next;
    logic [CNT_W-1:0] lo_reg, lo_next, hi_reg, hi_next, mid_reg, mid_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic [iprtl_pkg::STATUS_W-1:0] res_status_reg, res_status_next;
    logic [AW-1:0] res_start_reg, res_start_next, res_end_reg, res_end_next;
    logic [iprtl_pkg::INDEX_W-1:0] res_idx_reg, res_idx_next;
    logic m_tvalid_reg, m_tvalid_next;
    logic [iprtl_pkg::M_DATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [iprtl_pkg::M_USER_W-1:0] m_tuser_reg, m_tuser_next;

    logic              ram_we;
    logic [RAM_AW-1:0] ram_waddr, ram_raddr;
    logic [KEY_W-1:0]  ram_wdata, ram_rdata;

    logic [CNT_W-1:0] cnt_sel, jm1, ip1, mid_calc;
    logic [KEY_W-1:0] cmp_a, cmp_b;
    logic             cmp_lt;
    logic [AW-1:0]    ent_start, ent_end;

    iprtl_ram #(
        .WIDTH (KEY_W),
        .DEPTH (RAM_D)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign cnt_sel   = sel_reg ? blk_cnt_reg : acc_cnt_reg;
    assign jm1       = j_reg - CNT_W'(1);
    assign ip1       = i_reg + CNT_W'(1);
    assign mid_calc  = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign ent_start = ram_rdata[KEY_W-1:AW];
    assign ent_end   = ram_rdata[AW-1:0];

    // Shared 64-bit compare: sort key order, or entry end below address
    always_comb begin
        if (state_reg == S_SC) begin
            cmp_a = key_reg;
            cmp_b = ram_rdata;
        end else begin
            cmp_a = {ent_end, {AW{1'b0}}};
            cmp_b = {addr_reg, {AW{1'b0}}};
        end
    end
    assign cmp_lt = cmp_a < cmp_b;

    always_comb begin
        state_next      = state_reg;
        op_next         = op_reg;
        sel_next        = sel_reg;
        rs_next         = rs_reg;
        re_next         = re_reg;
        addr_next       = addr_reg;
        acc_cnt_next    = acc_cnt_reg;
        blk_cnt_next    = blk_cnt_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        mid_next        = mid_reg;
        key_next        = key_reg;
        res_status_next = res_status_reg;
        res_start_next  = res_start_reg;
        res_end_next    = res_end_reg;
        res_idx_next    = res_idx_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;
        ram_we          = 1'b0;
        ram_waddr       = '0;
        ram_wdata       = '0;
        ram_raddr       = '0;

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    op_next    = s_tuser[1:0];
                    sel_next   = s_tuser[2];
                    rs_next    = s_tdata[31:0];
                    re_next    = s_tdata[63:32];
                    addr_next  = s_tdata[95:64];
                    state_next = S_DEC;
                end
            end
            S_DEC: begin
                res_status_next = iprtl_pkg::ST_DONE;
                res_start_next  = '0;
                res_end_next    = '0;
                res_idx_next    = '0;
                state_next      = S_FIN;
                case (op_reg)
                    iprtl_pkg::OP_INSERT: begin
                        if (cnt_sel >= CNT_W'(TABLE_ENTRIES)) begin
                            res_status_next = iprtl_pkg::ST_FULL;
                        end else begin
                            ram_we    = 1'b1;
                            ram_waddr = {sel_reg, cnt_sel[IDX_W-1:0]};
                            ram_wdata = {rs_reg, re_reg};
                            if (sel_reg) begin
                                blk_cnt_next = blk_cnt_reg + CNT_W'(1);
                            end else begin
                                acc_cnt_next = acc_cnt_reg + CNT_W'(1);
                            end
                        end
                    end
                    iprtl_pkg::OP_CLEAR: begin
                        if (sel_reg) begin
                            blk_cnt_next = '0;
                        end else begin
                            acc_cnt_next = '0;
                        end
                    end
                    iprtl_pkg::OP_BUILD: begin
                        if (cnt_sel > CNT_W'(1)) begin
                            i_next     = CNT_W'(1);
                            state_next = S_SI;
                        end
                    end
                    default: begin
                        res_status_next = iprtl_pkg::ST_MISS;
                        lo_next         = '0;
                        hi_next         = cnt_sel;
                        state_next      = S_LK;
                    end
                endcase
            end
            S_SI: begin
                ram_raddr  = {sel_reg, i_reg[IDX_W-1:0]};
                j_next     = i_reg;
                state_next = S_SK;
            end
            S_SK: begin
                key_next   = ram_rdata;
                state_next = S_SJ;
            end
            S_SJ: begin
                if (j_reg == '0) begin
                    ram_we    = 1'b1;
                    ram_waddr = {sel_reg, j_reg[IDX_W-1:0]};
                    ram_wdata = key_reg;
                    i_next    = ip1;
                    state_next = (ip1 >= cnt_sel) ? S_FIN : S_SI;
                end else begin
                    ram_raddr  = {sel_reg, jm1[IDX_W-1:0]};
                    state_next = S_SC;
                end
            end
            S_SC: begin
                ram_we    = 1'b1;
                ram_waddr = {sel_reg, j_reg[IDX_W-1:0]};
                if (cmp_lt) begin
                    // shift the larger entry up one slot
                    ram_wdata  = ram_rdata;
                    j_next     = jm1;
                    state_next = S_SJ;
                end else begin
                    ram_wdata  = key_reg;
                    i_next     = ip1;
                    state_next = (ip1 >= cnt_sel) ? S_FIN : S_SI;
                end
            end
            S_LK: begin
                if (lo_reg < hi_reg) begin
                    ram_raddr  = {sel_reg, mid_calc[IDX_W-1:0]};
                    mid_next   = mid_calc;
                    state_next = S_LC;
                end else begin
                    state_next = S_FIN;
                end
            end
            S_LC: begin
                if (cmp_lt) begin
                    lo_next    = mid_reg + CNT_W'(1);
                    state_next = S_LK;
                end else if (ent_start > addr_reg) begin
                    hi_next    = mid_reg;
                    state_next = S_LK;
                end else begin
                    res_status_next = iprtl_pkg::ST_FOUND;
                    res_start_next  = ent_start;
                    res_end_next    = ent_end;
                    res_idx_next    = iprtl_pkg::INDEX_W'(mid_reg);
                    state_next      = S_FIN;
                end
            end
            S_FIN: begin
                // hold until the output register is free
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = res_status_reg;
                    m_tdata_next  = {6'd0, res_idx_reg, res_end_reg, res_start_reg};
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            acc_cnt_reg  <= '0;
            blk_cnt_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            acc_cnt_reg  <= acc_cnt_next;
            blk_cnt_reg  <= blk_cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        op_reg         <= op_next;
        sel_reg        <= sel_next;
        rs_reg         <= rs_next;
        re_reg         <= re_next;
        addr_reg       <= addr_next;
        i_reg          <= i_next;
        j_reg          <= j_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        mid_reg        <= mid_next;
        key_reg        <= key_next;
        res_status_reg <= res_status_next;
        res_start_reg  <= res_start_next;
        res_end_reg    <= res_end_next;
        res_idx_reg    <= res_idx_next;
        m_tdata_reg    <= m_tdata_next;
        m_tuser_reg    <= m_tuser_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (acc_cnt_reg <= CNT_W'(TABLE_ENTRIES)) && (blk_cnt_reg <= CNT_W'(TABLE_ENTRIES)))
        else $error("table count above capacity");

    a_window: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_LK || state_reg == S_LC) |-> (lo_reg <= hi_reg && hi_reg <= cnt_sel))
        else $error("search window out of range");

    a_mid: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_LC) |-> (mid_reg >= lo_reg && mid_reg < hi_reg))
        else $error("probe outside search window");

    a_sort_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SJ || state_reg == S_SC) |-> (j_reg <= i_reg && i_reg < cnt_sel))
        else $error("sort index out of order");

endmodule

// ===== tb/ip_range_checker.sv =====
`timescale 1ns / 100ps

module ip_range_checker #(
    parameter int TABLE_ENTRIES = iprtl_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [iprtl_pkg::S_DATA_W-1:0] s_tdata,
    input  logic [iprtl_pkg::S_USER_W-1:0] s_tuser,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [iprtl_pkg::M_DATA_W-1:0] m_tdata,
    input  logic [iprtl_pkg::M_USER_W-1:0] m_tuser,
    output int                             fail_count,
    output int                             words_pending
);

    typedef struct packed {
        logic [iprtl_pkg::STATUS_W-1:0] status;
        logic [iprtl_pkg::ADDR_W-1:0]   first;
        logic [iprtl_pkg::ADDR_W-1:0]   last;
        logic [iprtl_pkg::INDEX_W-1:0]  index;
    } lookup_answer_t;

    // Shadow tables, row 0 accept, row 1 block
    logic [iprtl_pkg::ADDR_W-1:0] range_lo [2][TABLE_ENTRIES];
    logic [iprtl_pkg::ADDR_W-1:0] range_hi [2][TABLE_ENTRIES];
    int unsigned                  range_fill [2];
    lookup_answer_t               answers_due [$];

    // Order by start, then by end among equal starts
    function automatic void sort_ranges(int t);
        int unsigned                  j;
        logic [iprtl_pkg::ADDR_W-1:0] s;
        logic [iprtl_pkg::ADDR_W-1:0] e;
        for (int unsigned i = 1; i < range_fill[t]; i++) begin
            s = range_lo[t][i];
            e = range_hi[t][i];
            j = i;
            while (j > 0 && (s < range_lo[t][j-1] ||
                   (s == range_lo[t][j-1] && e < range_hi[t][j-1]))) begin
                range_lo[t][j] = range_lo[t][j-1];
                range_hi[t][j] = range_hi[t][j-1];
                j--;
            end
            range_lo[t][j] = s;
            range_hi[t][j] = e;
        end
    endfunction

    function automatic lookup_answer_t apply_word(logic [iprtl_pkg::OP_W-1:0] op, int t,
                                                  logic [iprtl_pkg::ADDR_W-1:0] rs,
                                                  logic [iprtl_pkg::ADDR_W-1:0] re,
                                                  logic [iprtl_pkg::ADDR_W-1:0] ad);
        lookup_answer_t a;
        int unsigned    lo;
        int unsigned    hi;
        int unsigned    mid;
        a = '0;
        a.status = iprtl_pkg::ST_DONE;
        case (op)
            iprtl_pkg::OP_INSERT: begin
                if (range_fill[t] >= TABLE_ENTRIES) begin
                    a.status = iprtl_pkg::ST_FULL;
                end else begin
                    range_lo[t][range_fill[t]] = rs;
                    range_hi[t][range_fill[t]] = re;
                    range_fill[t]++;
                end
            end
            iprtl_pkg::OP_CLEAR: begin
                range_fill[t] = 0;
            end
            iprtl_pkg::OP_BUILD: begin
                sort_ranges(t);
            end
            default: begin
                lo = 0;
                hi = range_fill[t];
                a.status = iprtl_pkg::ST_MISS;
                while (lo < hi) begin
                    mid = lo + (hi - lo) / 2;
                    if (range_hi[t][mid] < ad) begin
                        lo = mid + 1;
                    end else if (range_lo[t][mid] > ad) begin
                        hi = mid;
                    end else begin
                        a.status = iprtl_pkg::ST_FOUND;
                        a.first  = range_lo[t][mid];
                        a.last   = range_hi[t][mid];
                        a.index  = mid[iprtl_pkg::INDEX_W-1:0];
                        break;
                    end
                end
            end
        endcase
        return a;
    endfunction

    task automatic flag_mismatch(string field, logic [iprtl_pkg::ADDR_W-1:0] want,
                                 logic [iprtl_pkg::ADDR_W-1:0] got);
        if (fail_count < 10)
            $display("mismatch in %s: expected %h, got %h", field, want, got);
        fail_count++;
    endtask

    assign words_pending = answers_due.size();

    always @(posedge aclk) begin
        lookup_answer_t want;
        if (!aresetn) begin
            range_fill[0] = 0;
            range_fill[1] = 0;
            answers_due.delete();
        end else begin
            if (s_tvalid && s_tready)
                answers_due = {answers_due,
                               apply_word(s_tuser[1:0], int'(s_tuser[2]),
                                          s_tdata[31:0], s_tdata[63:32],
                                          s_tdata[95:64])};
            if (m_tvalid && m_tready) begin
                if (answers_due.size() == 0) begin
                    if (fail_count < 10)
                        $display("unexpected result word: status %0d", m_tuser);
                    fail_count++;
                end else begin
                    want = answers_due.pop_front();
                    if (m_tuser != want.status)
                        flag_mismatch("status", want.status, m_tuser);
                    if (m_tdata[31:0] != want.first)
                        flag_mismatch("found_start", want.first, m_tdata[31:0]);
                    if (m_tdata[63:32] != want.last)
                        flag_mismatch("found_end", want.last, m_tdata[63:32]);
                    if (m_tdata[73:64] != want.index)
                        flag_mismatch("entry_index", want.index, m_tdata[73:64]);
                    if (m_tdata[79:74] != '0)
                        flag_mismatch("pad", '0, m_tdata[79:74]);
                end
            end
        end
    end

    initial fail_count = 0;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

    localparam int ENTRIES   = iprtl_pkg::TABLE_ENTRIES_DEF;
    localparam int MAX_TICKS = 3000000;
    localparam int FILL_STEP = 4194304;     // address span per entry when filling a table

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [iprtl_pkg::S_DATA_W-1:0] s_tdata = '0;
    logic [iprtl_pkg::S_USER_W-1:0] s_tuser = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [iprtl_pkg::M_DATA_W-1:0] m_tdata;
    logic [iprtl_pkg::M_USER_W-1:0] m_tuser;
    int                             fail_count;
    int                             words_pending;
    int                             ticks = 0;
    bit                             no_gaps = 1'b0;   // set for stretches without idling

    // Addresses of stored ranges, kept only to aim lookups at them
    logic [31:0] aim_points [$];

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    ip_range_table_lookup uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    ip_range_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .fail_count    (fail_count),
        .words_pending (words_pending)
    );

    // Watchdog: end the run if the block hangs
    always @(posedge aclk) begin
        ticks <= ticks + 1;
        if (ticks > MAX_TICKS) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Receiver: stall a random number of cycles before taking each result word, except in no-gap stretches
    initial begin
        int pause;
        @(posedge aclk);
        forever begin
            pause = no_gaps ? 0 : $urandom_range(0, 19);
            if (pause > 0) begin
                m_tready <= 1'b0;
                repeat (pause) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // Present one word; hold valid across back-to-back words, drop it only
    // when a gap follows
    task automatic push_word(logic [iprtl_pkg::OP_W-1:0] op, bit sel, logic [31:0] rs,
                             logic [31:0] re, logic [31:0] ad);
        int pause;
        pause = no_gaps ? 0 : $urandom_range(0, 19);
        if (pause > 0) begin
            s_tvalid <= 1'b0;
            repeat (pause) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= {sel, op};
        s_tdata  <= {ad, re, rs};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic add_range(bit sel, logic [31:0] rs, logic [31:0] re);
        push_word(iprtl_pkg::OP_INSERT, sel, rs, re, $urandom());
        aim_points = {aim_points, rs, re};
    endtask

    // Aim most lookups at or next to a stored bound, the rest anywhere
    function automatic logic [31:0] pick_address();
        logic [31:0] p;
        if (aim_points.size() == 0 || $urandom_range(0, 3) == 0)
            return $urandom();
        p = aim_points[$urandom_range(0, aim_points.size() - 1)];
        case ($urandom_range(0, 3))
            0: return p - 1;
            1: return p + 1;
            default: return p;
        endcase
    endfunction

    initial begin
        int          sent;
        int          n;
        bit          sel;
        logic [31:0] rs;
        logic [31:0] re;
        logic [31:0] pick;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty table, extreme bounds, reversed range, unsorted search
        push_word(iprtl_pkg::OP_CLEAR, 1'b0, '0, '0, '0);
        push_word(iprtl_pkg::OP_LOOKUP, 1'b0, '1, '1, 32'd5);
        add_range(1'b0, 32'h0, 32'h0);
        add_range(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_range(1'b0, 32'h8000_0000, 32'h7FFF_FFFF);
        add_range(1'b0, 32'h10, 32'h20);
        push_word(iprtl_pkg::OP_LOOKUP, 1'b0, '0, '0, 32'h0);
        push_word(iprtl_pkg::OP_LOOKUP, 1'b0, '0, '0, 32'hFFFF_FFFF);
        push_word(iprtl_pkg::OP_LOOKUP, 1'b0, '0, '0, 32'h8000_0000);
        push_word(iprtl_pkg::OP_BUILD, 1'b0, '1, '1, '1);
        push_word(iprtl_pkg::OP_LOOKUP, 1'b0, '0, '0, 32'h0);
        push_word(iprtl_pkg::OP_LOOKUP, 1'b0, '0, '0, 32'h15);
        push_word(iprtl_pkg::OP_LOOKUP, 1'b0, '0, '0, 32'hFFFF_FFFF);
        push_word(iprtl_pkg::OP_LOOKUP, 1'b0, '0, '0, 32'h8000_0000);
        push_word(iprtl_pkg::OP_LOOKUP, 1'b0, '0, '0, 32'h21);
        push_word(iprtl_pkg::OP_CLEAR, 1'b1, '0, '0, '0);
        add_range(1'b1, 32'hAAAA_AAAA, 32'h5555_5555);
        add_range(1'b1, 32'h5555_5555, 32'hAAAA_AAAA);
        push_word(iprtl_pkg::OP_BUILD, 1'b1, '0, '0, '0);
        push_word(iprtl_pkg::OP_LOOKUP, 1'b1, '0, '0, 32'h6000_0000);
        add_range(1'b0, 32'h5, 32'h100);
        push_word(iprtl_pkg::OP_LOOKUP, 1'b0, '0, '0, 32'h50);
        sent = 22;

        // Random phases: mostly clear, fill with a handful of ranges, maybe sort,
        // then look up; sprinkle stray operations for noise
        while (sent < 360) begin
            pick = $urandom();
            sel = pick[0];
            no_gaps = ($urandom_range(0, 4) == 0);
            aim_points.delete();
            if ($urandom_range(0, 4) != 0) begin
                push_word(iprtl_pkg::OP_CLEAR, sel, $urandom(), $urandom(), $urandom());
                sent++;
            end
            n = $urandom_range(1, 14);
            for (int i = 0; i < n; i++) begin
                rs = $urandom();
                case ($urandom_range(0, 3))
                    0: re = $urandom();                    // may come out reversed
                    1: re = rs;
                    default: re = rs + $urandom_range(0, 65535);
                endcase
                if (re < rs && $urandom_range(0, 2) != 0)
                    re = '1;
                add_range(sel, rs, re);
                sent++;
            end
            if ($urandom_range(0, 3) != 0) begin
                push_word(iprtl_pkg::OP_BUILD, sel, $urandom(), $urandom(), $urandom());
                sent++;
            end
            n = $urandom_range(2, 12);
            for (int i = 0; i < n; i++) begin
                if ($urandom_range(0, 15) == 0) begin
                    pick = $urandom();
                    push_word(pick[iprtl_pkg::OP_W-1:0], pick[iprtl_pkg::OP_W],
                              $urandom(), $urandom(), $urandom());
                end else begin
                    push_word(iprtl_pkg::OP_LOOKUP, sel, $urandom(), $urandom(),
                              pick_address());
                end
                sent++;
            end
        end

        // Fill the accept table to capacity with ascending ranges (cheap sort),
        // overflow it, then search the full table
        no_gaps = 1'b0;
        aim_points.delete();
        push_word(iprtl_pkg::OP_CLEAR, 1'b0, '0, '0, '0);
        for (int i = 0; i < ENTRIES; i++) begin
            rs = i * FILL_STEP;
            add_range(1'b0, rs, rs + $urandom_range(0, FILL_STEP - 1));
        end
        push_word(iprtl_pkg::OP_INSERT, 1'b0, $urandom(), $urandom(), $urandom());
        push_word(iprtl_pkg::OP_LOOKUP, 1'b0, '0, '0, 32'hFFFF_FFFF);
        push_word(iprtl_pkg::OP_BUILD, 1'b0, '0, '0, '0);
        push_word(iprtl_pkg::OP_INSERT, 1'b0, $urandom(), $urandom(), $urandom());
        for (int i = 0; i < 30; i++)
            push_word(iprtl_pkg::OP_LOOKUP, 1'b0, '0, '0, pick_address());
        push_word(iprtl_pkg::OP_CLEAR, 1'b0, '0, '0, '0);
        push_word(iprtl_pkg::OP_LOOKUP, 1'b0, '0, '0, 32'h0);
        s_tvalid <= 1'b0;

        // Drain: let the checker log the last word, then wait for every answer
        @(posedge aclk);
        while (words_pending != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
